/* rtl/core/mts_pkg.sv */
// Shared types and codes for the min-tracking stack.
`timescale 1ns / 1ps

package mts_pkg;

	localparam int DATA_W   = 32;
	localparam int REQ_W    = 2;
	localparam int FILL_W   = 7;
	localparam int STATUS_W = 2;

	localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
	localparam logic [REQ_W-1:0] REQ_POP  = 2'd1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;   // input transfer this cycle
		logic rd_load;  // memory read data is valid, load the new top level
		logic out_load; // move the finished result into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic pop_read; // current request is a pop that leaves a level to fetch
	} sts_t;

endpackage

/* rtl/core/mts_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module mts_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/core/mts_ctrl.sv */
// Controller state machine of the min-tracking stack.
`timescale 1ns / 1ps

module mts_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  mts_pkg::sts_t sts,
	output mts_pkg::cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.accept   = (state_q == S_IDLE) && in_valid;
		cmd.rd_load  = (state_q == S_READ);
		cmd.out_load = (state_q == S_EMIT) && (!out_valid_q || out_ready);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = sts.pop_read ? S_READ : S_EMIT;
				end
			end
			S_READ: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (cmd.out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	// Only one request is in flight at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> !in_ready)
		else $error("input accepted while a request was still in flight");

	// A memory fetch always goes from the read state straight to the emit state.
	a_read_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |=> (state_q == S_EMIT))
		else $error("read state not followed by emit");

	// A pop with a fetch goes through the read state.
	a_pop_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && sts.pop_read) |=> cmd.rd_load)
		else $error("pop fetch skipped the read state");
`endif

endmodule

/* rtl/core/mts_datapath.sv */
// Datapath of the min-tracking stack: level storage, top registers and result register.
`timescale 1ns / 1ps

module mts_datapath #(
	parameter int DEPTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mts_pkg::cmd_t                       cmd,
	output mts_pkg::sts_t                       sts,
	input  logic [mts_pkg::REQ_W-1:0]           in_req,
	input  logic signed [mts_pkg::DATA_W-1:0]   in_value,
	output logic signed [mts_pkg::DATA_W-1:0]   out_top,
	output logic signed [mts_pkg::DATA_W-1:0]   out_min,
	output logic [mts_pkg::FILL_W-1:0]          out_fill,
	output logic                                out_empty,
	output logic [mts_pkg::STATUS_W-1:0]        out_status
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int DW = mts_pkg::DATA_W;

	logic [CW-1:0]                   count_q;
	logic signed [DW-1:0]            top_q;
	logic signed [DW-1:0]            min_q;
	logic [mts_pkg::STATUS_W-1:0]    status_q;

	logic                            full;
	logic                            empty;
	logic                            is_push;
	logic                            is_pop;
	logic signed [DW-1:0]            push_min;
	logic [CW-1:0]                   count_m2;
	logic                            wr_en;
	logic                            rd_en;
	logic [2*DW-1:0]                 rd_data;
	logic [CW+mts_pkg::FILL_W-1:0]   count_ext;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign is_push  = (in_req == mts_pkg::REQ_PUSH);
	assign is_pop   = (in_req == mts_pkg::REQ_POP);
	// The new level's running minimum folds the value into the minimum below it.
	assign push_min = (!empty && (min_q < in_value)) ? min_q : in_value;
	assign count_m2 = count_q - CW'(2);

	assign sts.pop_read = is_pop && (count_q > CW'(1));
	assign wr_en        = cmd.accept && is_push && !full;
	assign rd_en        = cmd.accept && sts.pop_read;

	mts_ram #(
		.WIDTH (2 * DW),
		.DEPTH (DEPTH)
	) u_level_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data ({push_min, in_value}),
		.rd_en   (rd_en),
		.rd_addr (count_m2[AW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.accept) begin
			if (is_push && !full) begin
				count_q <= count_q + CW'(1);
			end else if (is_pop && !empty) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			if (is_push && full) begin
				status_q <= mts_pkg::ST_FULL;
			end else if (is_pop && empty) begin
				status_q <= mts_pkg::ST_EMPTY;
			end else begin
				status_q <= mts_pkg::ST_OK;
			end
			if (is_push && !full) begin
				top_q <= in_value;
				min_q <= push_min;
			end
		end else if (cmd.rd_load) begin
			top_q <= rd_data[DW-1:0];
			min_q <= rd_data[2*DW-1:DW];
		end
	end

	assign count_ext = {{mts_pkg::FILL_W{1'b0}}, count_q};

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_top    <= empty ? '0 : top_q;
			out_min    <= empty ? '0 : min_q;
			out_fill   <= count_ext[mts_pkg::FILL_W-1:0];
			out_empty  <= empty;
			out_status <= status_q;
		end
	end

`ifndef SYNTHESIS
	// The fill count never passes the stack depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("stack count exceeds depth");

	// A dropped push leaves the count unchanged.
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && is_push && full) |=> (count_q == CW'(DEPTH)))
		else $error("push on full changed the count");

	// An ignored pop leaves the stack empty.
	a_empty_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && is_pop && empty) |=> (count_q == '0))
		else $error("pop on empty changed the count");
`endif

endmodule

/* rtl/core/min_tracking_stack_unit.sv */
// Min-tracking stack: a bounded stack of signed values that reports its minimum.
//
// Requests arrive on the s_ stream: s_tuser carries the request kind (push, pop,
// peek; codes 2 and 3 both act as a peek) and s_tdata the value to push. Every
// request produces exactly one result transfer on the m_ stream with the top
// value, the minimum of all stored values, the fill count, an empty flag and a
// status code (ok, push on full dropped, pop on empty ignored). Top and minimum
// read zero while the stack is empty.
// Each level stores its value with the running minimum of itself and all levels
// below, in one RAM with a registered read port; the current top level is also
// held in registers. A request that needs no RAM fetch goes from the input
// transfer to the emit state, which loads its result into the output register;
// a pop that leaves levels behind first passes the read state, which loads the
// new top level from the RAM. One request is in flight at a time; s_tready
// rises at the edge that loads the result, and only then is the next one taken.
// Reset empties the stack at once; no clearing pass runs. If the receiver
// stalls, the result waits in the output register and the next request is still
// processed, but its result holds in the datapath until the output is taken.
`timescale 1ns / 1ps

module min_tracking_stack_unit #(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] push_value
	input  logic [1:0]  s_tuser,  // [1:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // [31:0] top_value, [63:32] min_value,
	                              // [70:64] fill_count, [71] is_empty
	output logic [1:0]  m_tuser   // [1:0] status
);

	mts_pkg::cmd_t cmd;
	mts_pkg::sts_t sts;

	logic signed [mts_pkg::DATA_W-1:0] out_top;
	logic signed [mts_pkg::DATA_W-1:0] out_min;
	logic [mts_pkg::FILL_W-1:0]        out_fill;
	logic                              out_empty;
	logic [mts_pkg::STATUS_W-1:0]      out_status;

	mts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mts_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_req     (s_tuser),
		.in_value   (s_tdata),
		.out_top    (out_top),
		.out_min    (out_min),
		.out_fill   (out_fill),
		.out_empty  (out_empty),
		.out_status (out_status)
	);

	assign m_tdata = {out_empty, out_fill, out_min, out_top};
	assign m_tuser = out_status;

endmodule
